// ----- src/f64f32_pkg.sv -----
// package with format defaults and rounding mode codes for the narrowing converter
`timescale 1ns / 1ps
package f64f32_pkg;

  localparam int ExpBitsDef  = 8;
  localparam int FracBitsDef = 23;

  typedef enum logic [1:0] {
    RndMagUp   = 2'd0,
    RndTrunc   = 2'd1,
    RndNearEven = 2'd2,
    RndUnused  = 2'd3
  } round_mode_e;

  localparam round_mode_e RndReset = RndNearEven;

endpackage

// ----- src/float64_to_float32_narrowing.sv -----
// binary64 to narrow binary float converter with selectable rounding
//
// usage:
//   s_axis carries one binary64 word per transfer in s_axis_tdata_i.
//   m_axis returns the converted word in m_axis_tdata_o, low 32 bits of
//   sign, exponent and fraction in the EXP_WIDTH / FRAC_BITS format.
//   cfg_valid_i / cfg_ready_o write the 2-bit rounding mode from
//   cfg_data_i; cfg_ready_o is always high. write it only while idle.
// path: an accepted word goes into the input register, then through the
//   convert logic into the result register.
// throughput: one word per cycle while m_axis_tready_i is high; a fresh
//   word is taken every cycle while the result register drains, set by
//   the single shift-and-round stage.
// stall: when m_axis_tready_i is low the result holds, the input register
//   still fills once, then s_axis_tready_o drops until the result leaves.
// reset: rst_ni low empties both registers and sets rounding mode to
//   round to nearest even.
`timescale 1ns / 1ps
module float64_to_float32_narrowing #(
  parameter int EXP_WIDTH = f64f32_pkg::ExpBitsDef,
  parameter int FRAC_BITS = f64f32_pkg::FracBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_data_i,      // round_mode
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [63:0] s_axis_tdata_i,  // value_bits
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o   // result_bits
);

  localparam int W    = 1 + EXP_WIDTH + FRAC_BITS;
  localparam int BIAS = (1 << (EXP_WIDTH - 1)) - 1;
  localparam int EMAX = (1 << EXP_WIDTH) - 1;
  localparam int SH   = 52 - FRAC_BITS;
  localparam logic [52:0] STK_MASK = (53'd1 << (SH - 1)) - 53'd1;
  localparam int SUB_OFS = 1076 - FRAC_BITS - BIAS;

  logic [1:0]  mode_q;
  logic        in_v_q;
  logic [63:0] in_q;
  logic        out_v_q;
  logic [31:0] out_q;
  logic        out_rdy;
  logic        in_rdy;
  logic [31:0] res_d;

  assign out_rdy         = !out_v_q || m_axis_tready_i;
  assign in_rdy          = !in_v_q || out_rdy;
  assign s_axis_tready_o = in_rdy;
  assign cfg_ready_o     = 1'b1;
  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tdata_o  = out_q;

  // conversion
  logic                  sgn;
  logic [10:0]           ef;
  logic [51:0]           fr;
  logic [52:0]           m;
  logic signed [12:0]    tgt;
  logic signed [12:0]    sub_sh;
  logic [FRAC_BITS:0]    kept;
  logic [FRAC_BITS+1:0]  kept_inc;
  logic                  grd;
  logic                  stk;
  logic                  inc;
  logic [63:0]           m64;
  logic [5:0]            s6;
  logic [63:0]           shifted;
  logic [63:0]           sh_g;
  logic [63:0]           smask;
  logic [EXP_WIDTH-1:0]  exp_o;
  logic [W-1:0]          res_w;
  logic                  norm;

  always_comb begin
    sgn      = in_q[63];
    ef       = in_q[62:52];
    fr       = in_q[51:0];
    m        = {1'b1, fr};
    m64      = {11'd0, m};
    tgt      = $signed({2'b00, ef}) - 13'sd1023 + 13'(BIAS);
    sub_sh   = 13'(SUB_OFS) - $signed({2'b00, ef});
    norm     = (tgt >= 13'sd1);
    s6       = sub_sh[5:0];
    shifted  = m64 >> s6;
    sh_g     = m64 >> (s6 - 6'd1);
    smask    = (64'd1 << (s6 - 6'd1)) - 64'd1;
    kept     = '0;
    grd      = 1'b0;
    stk      = 1'b0;
    exp_o    = '0;
    res_w    = '0;
    if (norm) begin
      kept = m[52:SH];
      grd  = m[SH-1];
      stk  = |(m & STK_MASK);
    end else if (ef == 11'd0 || sub_sh > 13'sd63) begin
      stk = 1'b1;
    end else begin
      kept = shifted[FRAC_BITS:0];
      grd  = sh_g[0];
      stk  = |(m64 & smask);
    end
    case (mode_q)
      f64f32_pkg::RndMagUp:    inc = grd || stk;
      f64f32_pkg::RndNearEven: inc = grd && (stk || kept[0]);
      default:                 inc = 1'b0;
    endcase
    kept_inc = {1'b0, kept} + (FRAC_BITS + 2)'(inc);
    if (ef == 11'h7FF) begin
      if (fr != 52'd0) begin
        res_w = {1'b0, {EXP_WIDTH{1'b1}}, 1'b1, {(FRAC_BITS-1){1'b0}}};
      end else begin
        res_w = {sgn, {EXP_WIDTH{1'b1}}, {FRAC_BITS{1'b0}}};
      end
    end else if (ef == 11'd0 && fr == 52'd0) begin
      res_w = '0;
    end else if (tgt >= 13'(EMAX)) begin
      res_w = {sgn, {EXP_WIDTH{1'b1}}, {FRAC_BITS{1'b0}}};
    end else if (norm) begin
      if (kept_inc[FRAC_BITS+1]) begin
        if (tgt + 13'sd1 >= 13'(EMAX)) begin
          res_w = {sgn, {EXP_WIDTH{1'b1}}, {FRAC_BITS{1'b0}}};
        end else begin
          exp_o = EXP_WIDTH'(tgt + 13'sd1);
          res_w = {sgn, exp_o, {FRAC_BITS{1'b0}}};
        end
      end else begin
        exp_o = EXP_WIDTH'(tgt);
        res_w = {sgn, exp_o, kept_inc[FRAC_BITS-1:0]};
      end
    end else begin
      // subnormal, a carry lands in the exponent field
      res_w = {sgn, (EXP_WIDTH + FRAC_BITS)'(kept_inc[FRAC_BITS:0])};
    end
    res_d = 32'(res_w);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= f64f32_pkg::RndReset;
      in_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        mode_q <= cfg_data_i;
      end
      if (in_rdy) begin
        in_v_q <= s_axis_tvalid_i;
      end
      if (out_rdy) begin
        out_v_q <= in_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_rdy && s_axis_tvalid_i) begin
      in_q <= s_axis_tdata_i;
    end
    if (out_rdy && in_v_q) begin
      out_q <= res_d;
    end
  end

  a_in_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> in_v_q)
    else $error("accepted word not held in input register");

  a_moves_on: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_v_q && out_rdy |=> m_axis_tvalid_o)
    else $error("input word did not reach result register");

  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_v_q && m_axis_tvalid_o && !m_axis_tready_i |-> !s_axis_tready_o)
    else $error("input taken while both registers full and stalled");

endmodule

// ----- verif/testbench.sv -----
// testbench for the binary64 to binary32 narrowing converter with self-checking prediction
`timescale 1ns / 1ps
module testbench;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [1:0]  cfg_data_i;      // round_mode
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [63:0] s_axis_tdata_i;  // value_bits
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [31:0] m_axis_tdata_o;  // result_bits

  float64_to_float32_narrowing dut (.*);

  logic [63:0] pending_words[$];
  logic [31:0] expected_singles[$];
  f64f32_pkg::round_mode_e active_mode;
  int          error_count;
  int          checked_count;
  int          send_gap;
  int          recv_gap;
  int          hold_cycles;
  int          mode_pass;

  function automatic bit round_up(logic [63:0] kept, bit guard, bit sticky);
    case (active_mode)
      f64f32_pkg::RndMagUp:    return guard | sticky;
      f64f32_pkg::RndNearEven: return guard & (sticky | kept[0]);
      default:                 return 1'b0;
    endcase
  endfunction

  function automatic logic [31:0] narrow_double(logic [63:0] x);
    logic        sgn;
    logic [10:0] efield;
    logic [51:0] frac;
    logic [63:0] mant;
    logic [63:0] kept;
    int          expo;
    int          target;
    int          shift;
    bit          guard;
    bit          sticky;
    sgn = x[63];
    efield = x[62:52];
    frac = x[51:0];
    if (efield == 11'h7ff) begin
      if (frac != 0) return 32'h7fc0_0000;
      return {sgn, 8'hff, 23'd0};
    end
    if (efield == 0 && frac == 0) return 32'd0;
    if (efield == 0) begin
      mant = {12'd0, frac};
      expo = -1022;
      while (mant[52] == 1'b0) begin
        mant = mant << 1;
        expo--;
      end
    end else begin
      mant = {11'd0, 1'b1, frac};
      expo = int'(efield) - 1023;
    end
    target = expo + 127;
    if (target >= 255) return {sgn, 8'hff, 23'd0};
    if (target >= 1) begin
      kept = mant >> 29;
      guard = mant[28];
      sticky = mant[27:0] != 0;
      if (round_up(kept, guard, sticky)) begin
        kept++;
        if (kept >= 64'd1 << 24) begin
          kept = kept >> 1;
          target++;
          if (target >= 255) return {sgn, 8'hff, 23'd0};
        end
      end
      return {sgn, target[7:0], kept[22:0]};
    end
    shift = 29 + (-126 - expo);
    if (shift > 63) begin
      kept = 0;
      guard = 0;
      sticky = 1;
    end else begin
      kept = mant >> shift;
      guard = mant[shift-1];
      sticky = (mant & ((64'd1 << (shift - 1)) - 1)) != 0;
    end
    if (round_up(kept, guard, sticky)) kept++;
    return {sgn, kept[30:0]};
  endfunction

  function automatic logic [63:0] random_double();
    logic [63:0] w;
    int          pick;
    w = {$urandom, $urandom};
    pick = $urandom_range(0, 9);
    case (pick)
      0, 1, 2, 3: w[62:52] = 11'd896 + 11'($urandom_range(0, 130));
      4:          w[62:52] = 11'd840 + 11'($urandom_range(0, 60));
      5:          w[28:0] = ($urandom_range(0, 1) != 0) ? 29'h1000_0000 : 29'h0fff_ffff;
      6:          begin
        w[62:52] = 11'd1150 + 11'($urandom_range(0, 3));
        w[51:29] = '1;
      end
      default: ;
    endcase
    return w;
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #50_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
      s_axis_tdata_i  <= '0;
      send_gap        <= 0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        expected_singles.push_back(narrow_double(s_axis_tdata_i));
        void'(pending_words.pop_front());
      end
      if (s_axis_tvalid_i && !s_axis_tready_o) begin
      end else if (send_gap > 0) begin
        s_axis_tvalid_i <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (pending_words.size() > 0) begin
        s_axis_tvalid_i <= 1'b1;
        s_axis_tdata_i  <= pending_words[0];
        send_gap        <= (mode_pass % 2 == 0) ? $urandom_range(0, 5) : 0;
      end else begin
        s_axis_tvalid_i <= 1'b0;
      end
    end
  end

  // long receiver hold
  always @(posedge clk_i) begin
    if (hold_cycles > 0)
      hold_cycles <= hold_cycles - 1;
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
      recv_gap        <= 0;
    end else begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        checked_count++;
        if (expected_singles.size() == 0) begin
          $error("result_bits word with nothing expected: %h", m_axis_tdata_o);
          error_count++;
        end else begin
          if (m_axis_tdata_o !== expected_singles[0]) begin
            $error("result_bits mismatch: expected %h actual %h",
                   expected_singles[0], m_axis_tdata_o);
            error_count++;
          end
          void'(expected_singles.pop_front());
        end
      end
      if (hold_cycles > 0) begin
        m_axis_tready_i <= 1'b0;
      end else if (recv_gap > 0) begin
        m_axis_tready_i <= 1'b0;
        recv_gap <= recv_gap - 1;
      end else begin
        m_axis_tready_i <= 1'b1;
        if (m_axis_tvalid_o && m_axis_tready_i)
          recv_gap <= (mode_pass % 2 == 0) ? $urandom_range(0, 5) : 0;
      end
    end
  end

  task automatic drain_and_settle();
    while (pending_words.size() != 0 || s_axis_tvalid_i || expected_singles.size() != 0)
      @(posedge clk_i);
    repeat (5) @(posedge clk_i);
  endtask

  task automatic set_round_mode(f64f32_pkg::round_mode_e m);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= m;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    active_mode = m;
  endtask

  initial begin
    f64f32_pkg::round_mode_e modes[5];
    logic [63:0] directed[$];
    directed = '{64'h0, 64'h8000_0000_0000_0000, 64'h7ff0_0000_0000_0000,
                 64'hfff0_0000_0000_0000, 64'h7ff8_0000_0000_0000, 64'hfff0_0000_0000_0001,
                 64'h3ff0_0000_0000_0000, 64'hbff0_0000_1000_0000, 64'h3ff0_0000_3000_0000,
                 64'h3ff0_0000_1000_0001, 64'h47ef_ffff_e000_0000, 64'hc7ef_ffff_f000_0000,
                 64'h47f0_0000_0000_0000, 64'h7fef_ffff_ffff_ffff, 64'h380f_ffff_f000_0000,
                 64'h3810_0000_0000_0000, 64'h36a0_0000_0000_0000, 64'hb690_0000_0000_0001,
                 64'h0000_0000_0000_0001, 64'h800f_ffff_ffff_ffff, 64'h3690_0000_0000_0000,
                 64'h3ff0_0000_2000_0000};
    modes = '{f64f32_pkg::RndNearEven, f64f32_pkg::RndMagUp, f64f32_pkg::RndTrunc,
              f64f32_pkg::RndUnused, f64f32_pkg::RndNearEven};
    error_count = 0;
    checked_count = 0;
    hold_cycles = 0;
    mode_pass = 0;
    active_mode = f64f32_pkg::RndReset;
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_data_i = '0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i = '0;
    m_axis_tready_i = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (modes[i]) begin
      mode_pass = i;
      if (i != 0) set_round_mode(modes[i]);
      foreach (directed[j]) pending_words.push_back(directed[j]);
      for (int k = 0; k < 300; k++) pending_words.push_back(random_double());
      if (i == 1) begin
        repeat (3) @(posedge clk_i);
        hold_cycles = 60;
      end
      drain_and_settle();
    end
    $display("covered %0d conversions over all rounding modes incl. unused code",
             checked_count);
    $display("directed specials, subnormal/overflow edges, long output stall");
    if (error_count == 0 && expected_singles.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
